@@ hdl/ucdp_pkg.sv @@
// shared types and constants of the configuration descriptor parser
package ucdp_pkg;

  // descriptor type codes
  localparam logic [7:0] KindInterface = 8'd4;
  localparam logic [7:0] KindEndpoint  = 8'd5;

  // smallest lengths that count
  localparam logic [7:0] MinDescLen  = 8'd2;
  localparam logic [7:0] MinEpLen    = 8'd7;
  localparam logic [7:0] MinIfaceLen = 8'd9;

  // capture slots
  localparam int unsigned CapSlots   = 5;
  localparam int unsigned ClassSlots = 3;

  // byte offsets of the captured fields
  localparam logic [7:0] EpFirstPos    = 8'd2;
  localparam logic [7:0] IfaceFirstPos = 8'd5;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // record kinds
  typedef enum logic {
    RecEndpoint = 1'b0,
    RecSummary  = 1'b1
  } rec_kind_e;

  // one queued job: an endpoint record, a summary, or both
  typedef struct packed {
    logic        emit_ep;
    logic        emit_sum;
    logic [3:0]  ep_number;
    logic        ep_dir_in;
    logic [1:0]  ep_xfer_type;
    logic [10:0] ep_max_packet;
    logic [7:0]  ep_interval;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic [4:0]  ep_total;
    logic        stopped_early;
  } job_t;

endpackage

@@ hdl/ucdp_front.sv @@
// front part: walks the descriptor chain and queues record jobs
module ucdp_front #(
  parameter int unsigned MAX_ENDPOINTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_buffer_i,
  output logic            push_o,
  output ucdp_pkg::job_t  job_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] kind_q, kind_d;
  logic [7:0] cap_q [ucdp_pkg::CapSlots];
  logic [7:0] cap_d [ucdp_pkg::CapSlots];
  logic [7:0] cls_q [ucdp_pkg::ClassSlots];
  logic [7:0] cls_d [ucdp_pkg::ClassSlots];
  logic [4:0] cnt_q, cnt_d;
  logic       halt_q, halt_d;

  logic       done;
  logic       overrun;
  logic       emit_ep;

  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    kind_d  = kind_q;
    cap_d   = cap_q;
    cls_d   = cls_q;
    cnt_d   = cnt_q;
    halt_d  = halt_q;
    done    = 1'b0;
    overrun = 1'b0;
    emit_ep = 1'b0;

    if (acc_i && !halt_q) begin
      if (pos_q == 8'd0) begin
        len_d  = data_byte_i;
        kind_d = 8'd0;
      end else if (pos_q == 8'd1) begin
        kind_d = data_byte_i;
        if (len_q < ucdp_pkg::MinDescLen) begin
          halt_d = 1'b1;
        end
      end else begin
        for (int i = 0; i < ucdp_pkg::CapSlots; i++) begin
          if (kind_q == ucdp_pkg::KindEndpoint && pos_q == ucdp_pkg::EpFirstPos + 8'(i)) begin
            cap_d[i] = data_byte_i;
          end
        end
        for (int i = 0; i < ucdp_pkg::ClassSlots; i++) begin
          if (kind_q == ucdp_pkg::KindInterface &&
              pos_q == ucdp_pkg::IfaceFirstPos + 8'(i)) begin
            cap_d[i] = data_byte_i;
          end
        end
      end

      if (!halt_d) begin
        done = (pos_q != 8'd0) && ({1'b0, pos_q} + 9'd1 == {1'b0, len_d});
        if (done) begin
          if (kind_d == ucdp_pkg::KindEndpoint && len_d >= ucdp_pkg::MinEpLen &&
              cnt_q < 5'(MAX_ENDPOINTS)) begin
            emit_ep = 1'b1;
            cnt_d   = cnt_q + 5'd1;
          end else if (kind_d == ucdp_pkg::KindInterface &&
                       len_d >= ucdp_pkg::MinIfaceLen && cls_q[0] == 8'd0) begin
            for (int i = 0; i < ucdp_pkg::ClassSlots; i++) begin
              cls_d[i] = cap_d[i];
            end
          end
          pos_d = 8'd0;
        end else begin
          overrun = end_of_buffer_i && (pos_q != 8'd0);
          pos_d   = pos_q + 8'd1;
        end
      end
    end

    // job built from the updated state
    job_o.emit_ep        = emit_ep;
    job_o.emit_sum       = acc_i && end_of_buffer_i;
    job_o.ep_number      = cap_d[0][3:0];
    job_o.ep_dir_in      = cap_d[0][7];
    job_o.ep_xfer_type   = cap_d[1][1:0];
    job_o.ep_max_packet  = {cap_d[3][2:0], cap_d[2]};
    job_o.ep_interval    = cap_d[4];
    job_o.iface_class    = cls_d[0];
    job_o.iface_subclass = cls_d[1];
    job_o.iface_protocol = cls_d[2];
    job_o.ep_total       = cnt_d;
    job_o.stopped_early  = halt_d || overrun;
    push_o               = emit_ep || (acc_i && end_of_buffer_i);

    // end of buffer clears everything
    if (acc_i && end_of_buffer_i) begin
      pos_d  = 8'd0;
      len_d  = 8'd0;
      kind_d = 8'd0;
      cnt_d  = 5'd0;
      halt_d = 1'b0;
      for (int i = 0; i < ucdp_pkg::CapSlots; i++) begin
        cap_d[i] = 8'd0;
      end
      for (int i = 0; i < ucdp_pkg::ClassSlots; i++) begin
        cls_d[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      len_q  <= 8'd0;
      kind_q <= 8'd0;
      cnt_q  <= 5'd0;
      halt_q <= 1'b0;
      for (int i = 0; i < ucdp_pkg::CapSlots; i++) begin
        cap_q[i] <= 8'd0;
      end
      for (int i = 0; i < ucdp_pkg::ClassSlots; i++) begin
        cls_q[i] <= 8'd0;
      end
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
      cap_q  <= cap_d;
      cls_q  <= cls_d;
    end
  end

endmodule

@@ hdl/ucdp_queue.sv @@
// small job queue between front and back
module ucdp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ucdp_pkg::job_t  push_job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            nonempty_o,
  output ucdp_pkg::job_t  head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ucdp_pkg::job_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

@@ hdl/ucdp_back.sv @@
// back part: turns queued jobs into output words
module ucdp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  ucdp_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            record_kind_o,
  output logic [3:0]      ep_number_o,
  output logic            ep_dir_in_o,
  output logic [1:0]      ep_xfer_type_o,
  output logic [10:0]     ep_max_packet_o,
  output logic [7:0]      ep_interval_o,
  output logic [7:0]      iface_class_o,
  output logic [7:0]      iface_subclass_o,
  output logic [7:0]      iface_protocol_o,
  output logic [4:0]      ep_total_o,
  output logic            stopped_early_o,
  output logic            last_of_run_o
);

  logic vld_q, vld_d;
  logic half_q, half_d;   // endpoint word of the head job already sent
  logic load;
  logic send_ep;

  assign load    = job_valid_i && (!vld_q || !out_stall_i);
  assign send_ep = job_i.emit_ep && !half_q;

  always_comb begin
    vld_d  = vld_q && out_stall_i;
    half_d = half_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      if (send_ep && job_i.emit_sum) begin
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      half_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_ep) begin
        record_kind_o    <= ucdp_pkg::RecEndpoint;
        ep_number_o      <= job_i.ep_number;
        ep_dir_in_o      <= job_i.ep_dir_in;
        ep_xfer_type_o   <= job_i.ep_xfer_type;
        ep_max_packet_o  <= job_i.ep_max_packet;
        ep_interval_o    <= job_i.ep_interval;
        iface_class_o    <= 8'd0;
        iface_subclass_o <= 8'd0;
        iface_protocol_o <= 8'd0;
        ep_total_o       <= 5'd0;
        stopped_early_o  <= 1'b0;
        last_of_run_o    <= !job_i.emit_sum;
      end else begin
        record_kind_o    <= ucdp_pkg::RecSummary;
        ep_number_o      <= 4'd0;
        ep_dir_in_o      <= 1'b0;
        ep_xfer_type_o   <= 2'd0;
        ep_max_packet_o  <= 11'd0;
        ep_interval_o    <= 8'd0;
        iface_class_o    <= job_i.iface_class;
        iface_subclass_o <= job_i.iface_subclass;
        iface_protocol_o <= job_i.iface_protocol;
        ep_total_o       <= job_i.ep_total;
        stopped_early_o  <= job_i.stopped_early;
        last_of_run_o    <= 1'b1;
      end
    end
  end

  assign out_valid_o = vld_q;

endmodule

@@ hdl/usb_config_descriptor_parser_top.sv @@
// top level of the usb configuration descriptor parser
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | data_byte_i, end_of_buffer_i
//  out     | output    | out_valid_o / out_stall_i| record_kind_o .. last_of_run_o
//
// one input word per cycle while in_stall_o is low; the front updates the parse state in the cycle it takes a byte
// a job goes from the front through the job queue into the output register; a job that carries both an
// endpoint record and the summary occupies the output register for two words in a row
// in_stall_o rises only when the job queue is full, which happens only under output stall
// asynchronous active-low reset clears the parse state, the queue and the output valid
module usb_config_descriptor_parser_top #(
  parameter int unsigned MAX_ENDPOINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [3:0]  ep_number_o,
  output logic        ep_dir_in_o,
  output logic [1:0]  ep_xfer_type_o,
  output logic [10:0] ep_max_packet_o,
  output logic [7:0]  ep_interval_o,
  output logic [7:0]  iface_class_o,
  output logic [7:0]  iface_subclass_o,
  output logic [7:0]  iface_protocol_o,
  output logic [4:0]  ep_total_o,
  output logic        stopped_early_o,
  output logic        last_of_run_o
);

  logic           in_acc;
  logic           push;
  ucdp_pkg::job_t push_job;
  logic           q_full;
  logic           q_nonempty;
  ucdp_pkg::job_t head_job;
  logic           pop;

  // queue full is the only input back-pressure
  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i && !q_full;

  // parse state and job classification
  ucdp_front #(
    .MAX_ENDPOINTS (MAX_ENDPOINTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .push_o          (push),
    .job_o           (push_job)
  );

  // decouples parsing from output stalls
  ucdp_queue #(
    .DEPTH (ucdp_pkg::QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head_job)
  );

  // record formatting and output register
  ucdp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_nonempty),
    .job_i            (head_job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .ep_number_o      (ep_number_o),
    .ep_dir_in_o      (ep_dir_in_o),
    .ep_xfer_type_o   (ep_xfer_type_o),
    .ep_max_packet_o  (ep_max_packet_o),
    .ep_interval_o    (ep_interval_o),
    .iface_class_o    (iface_class_o),
    .iface_subclass_o (iface_subclass_o),
    .iface_protocol_o (iface_protocol_o),
    .ep_total_o       (ep_total_o),
    .stopped_early_o  (stopped_early_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

@@ tb/sv/usb_config_descriptor_parser_top_test.sv @@
// self-checking testbench for the usb configuration descriptor parser
`timescale 1ns / 100ps

module usb_config_descriptor_parser_top_test;

  // endpoint limit given to the block and mirrored by the parse model
  localparam int unsigned EpLimit      = 16;
  // generous bound on the whole run, in clock cycles
  localparam int unsigned CycleLimit   = 1000000;
  // rough count of input words in the random part
  localparam int unsigned WordTarget   = 2000;
  // quiet cycles after the last record, output never stalled then
  localparam int unsigned TailCycles   = 20;
  // mismatch lines printed before going quiet
  localparam int unsigned MaxReports   = 40;
  // configuration descriptor type, only used to build realistic buffers
  localparam logic [7:0]  KindConfig   = 8'd2;
  // last byte offsets of the captured endpoint and interface fields
  localparam int unsigned EpLastPos    = 6;
  localparam int unsigned IfaceLastPos = 7;

  // one word offered on the input channel
  typedef struct {
    logic [7:0] data;
    logic       eob;
    bit         hold;  // wait for every record to drain before offering
  } in_word_t;

  // one record seen on the output channel
  typedef struct packed {
    ucdp_pkg::rec_kind_e kind;
    logic [3:0]  ep_number;
    logic        ep_dir_in;
    logic [1:0]  ep_xfer_type;
    logic [10:0] ep_max_packet;
    logic [7:0]  ep_interval;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic [4:0]  ep_total;
    logic        stopped_early;
    logic        last_of_run;
  } record_t;

  // clock, reset and block ports, all driven ones known from time zero
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i      = 8'd0;
  logic        end_of_buffer_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        record_kind_o;
  logic [3:0]  ep_number_o;
  logic        ep_dir_in_o;
  logic [1:0]  ep_xfer_type_o;
  logic [10:0] ep_max_packet_o;
  logic [7:0]  ep_interval_o;
  logic [7:0]  iface_class_o;
  logic [7:0]  iface_subclass_o;
  logic [7:0]  iface_protocol_o;
  logic [4:0]  ep_total_o;
  logic        stopped_early_o;
  logic        last_of_run_o;

  // words not yet taken by the block, front one is on the bus
  in_word_t    pending_words[$];
  // records the block still owes, oldest first
  record_t     expected_recs[$];
  // buffer under construction
  logic [7:0]  buf_bytes[$];

  int unsigned word_total    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned idle_left     = 0;
  int unsigned in_calm_left  = 0;
  int unsigned stall_left    = 0;
  int unsigned out_calm_left = 0;
  logic        in_took       = 1'b0;  // front word was taken at the last rising edge
  bit          draining      = 1'b0;  // end of run: output never stalled

  // parse model state, mirrors the walk through the descriptor chain
  logic [7:0]  prs_pos;
  logic [7:0]  prs_len;
  logic [7:0]  prs_kind;
  logic [7:0]  prs_cap [ucdp_pkg::CapSlots];
  logic [7:0]  prs_class [ucdp_pkg::ClassSlots];
  logic [4:0]  prs_count;
  logic        prs_halt;

  usb_config_descriptor_parser_top #(
    .MAX_ENDPOINTS(EpLimit)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_buffer_i  (end_of_buffer_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .ep_number_o      (ep_number_o),
    .ep_dir_in_o      (ep_dir_in_o),
    .ep_xfer_type_o   (ep_xfer_type_o),
    .ep_max_packet_o  (ep_max_packet_o),
    .ep_interval_o    (ep_interval_o),
    .iface_class_o    (iface_class_o),
    .iface_subclass_o (iface_subclass_o),
    .iface_protocol_o (iface_protocol_o),
    .ep_total_o       (ep_total_o),
    .stopped_early_o  (stopped_early_o),
    .last_of_run_o    (last_of_run_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parse model
  // ---------------------------------------------------------------------------

  // state after reset and after every summary record
  task automatic clear_parse_state();
    prs_pos   = '0;
    prs_len   = '0;
    prs_kind  = '0;
    prs_count = '0;
    prs_halt  = 1'b0;
    for (int i = 0; i < ucdp_pkg::CapSlots; i++) prs_cap[i] = '0;
    for (int i = 0; i < ucdp_pkg::ClassSlots; i++) prs_class[i] = '0;
  endtask

  // advance the model by one taken word and queue the records it causes
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    int unsigned pos;
    bit          ep_hit;
    bit          overrun;
    record_t     rec;
    ep_hit  = 1'b0;
    overrun = 1'b0;
    if (!prs_halt) begin
      pos = prs_pos;
      if (pos == 0) begin
        prs_len  = b;
        prs_kind = '0;
      end else if (pos == 1) begin
        prs_kind = b;
        // a length below 2 stops the walk once the type byte is in
        if (prs_len < ucdp_pkg::MinDescLen) prs_halt = 1'b1;
      end else if (prs_kind == ucdp_pkg::KindEndpoint && pos <= EpLastPos) begin
        prs_cap[pos - ucdp_pkg::EpFirstPos] = b;
      end else if (prs_kind == ucdp_pkg::KindInterface && pos >= ucdp_pkg::IfaceFirstPos &&
                   pos <= IfaceLastPos) begin
        prs_cap[pos - ucdp_pkg::IfaceFirstPos] = b;
      end

      if (!prs_halt) begin
        if (pos >= 1 && pos + 1 == prs_len) begin
          // descriptor complete
          if (prs_kind == ucdp_pkg::KindEndpoint && prs_len >= ucdp_pkg::MinEpLen &&
              prs_count < EpLimit) begin
            ep_hit    = 1'b1;
            prs_count = prs_count + 5'd1;
          end else if (prs_kind == ucdp_pkg::KindInterface &&
                       prs_len >= ucdp_pkg::MinIfaceLen && prs_class[0] == '0) begin
            // class latch stays open while the latched class is zero
            for (int i = 0; i < ucdp_pkg::ClassSlots; i++) prs_class[i] = prs_cap[i];
          end
          prs_pos = '0;
        end else begin
          // buffer ends inside a descriptor past its length byte: dropped
          if (eob && pos >= 1) overrun = 1'b1;
          prs_pos = prs_pos + 8'd1;
        end
      end
    end

    if (ep_hit) begin
      rec               = '0;
      rec.kind          = ucdp_pkg::RecEndpoint;
      rec.ep_number     = prs_cap[0][3:0];
      rec.ep_dir_in     = prs_cap[0][7];
      rec.ep_xfer_type  = prs_cap[1][1:0];
      rec.ep_max_packet = {prs_cap[3][2:0], prs_cap[2]};
      rec.ep_interval   = prs_cap[4];
      // on the final byte the summary follows and carries the run end
      rec.last_of_run   = !eob;
      expected_recs.push_back(rec);
    end

    if (eob) begin
      rec                = '0;
      rec.kind           = ucdp_pkg::RecSummary;
      rec.iface_class    = prs_class[0];
      rec.iface_subclass = prs_class[1];
      rec.iface_protocol = prs_class[2];
      rec.ep_total       = prs_count;
      rec.stopped_early  = prs_halt | overrun;
      rec.last_of_run    = 1'b1;
      expected_recs.push_back(rec);
      clear_parse_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_records(input record_t want, input record_t got);
    check_field("record_kind", want.kind, got.kind);
    check_field("ep_number", want.ep_number, got.ep_number);
    check_field("ep_dir_in", want.ep_dir_in, got.ep_dir_in);
    check_field("ep_xfer_type", want.ep_xfer_type, got.ep_xfer_type);
    check_field("ep_max_packet", want.ep_max_packet, got.ep_max_packet);
    check_field("ep_interval", want.ep_interval, got.ep_interval);
    check_field("iface_class", want.iface_class, got.iface_class);
    check_field("iface_subclass", want.iface_subclass, got.iface_subclass);
    check_field("iface_protocol", want.iface_protocol, got.iface_protocol);
    check_field("ep_total", want.ep_total, got.ep_total);
    check_field("stopped_early", want.stopped_early, got.stopped_early);
    check_field("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  // monitor: samples both channels at the rising edge, before the block updates
  always @(posedge clk_i) begin
    record_t got;
    in_took <= in_valid_i && !in_stall_o;

    // output word first: it can never stem from the input word of this same edge
    if (out_valid_o && !out_stall_i) begin
      got.kind           = ucdp_pkg::rec_kind_e'(record_kind_o);
      got.ep_number      = ep_number_o;
      got.ep_dir_in      = ep_dir_in_o;
      got.ep_xfer_type   = ep_xfer_type_o;
      got.ep_max_packet  = ep_max_packet_o;
      got.ep_interval    = ep_interval_o;
      got.iface_class    = iface_class_o;
      got.iface_subclass = iface_subclass_o;
      got.iface_protocol = iface_protocol_o;
      got.ep_total       = ep_total_o;
      got.stopped_early  = stopped_early_o;
      got.last_of_run    = last_of_run_o;
      if (expected_recs.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: record with nothing expected, expected none, actual kind %0d",
                   $time, record_kind_o);
      end else begin
        compare_records(expected_recs.pop_front(), got);
      end
    end

    if (in_valid_i && !in_stall_o) begin
      parse_byte(data_byte_i, end_of_buffer_i);
      void'(pending_words.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // driving both channels at the falling edge
  // ---------------------------------------------------------------------------

  // mostly short idles, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // input driver, fed from pending_words
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // word offered but not taken yet: payload and valid stay put
    end else if (idle_left > 0) begin
      in_valid_i <= 1'b0;
      idle_left--;
    end else if (pending_words.size() != 0 &&
                 !(pending_words[0].hold && expected_recs.size() != 0)) begin
      data_byte_i     <= pending_words[0].data;
      end_of_buffer_i <= pending_words[0].eob;
      in_valid_i      <= 1'b1;
      // idle to insert after this word is taken, with calm stretches now and then
      if (in_calm_left > 0) begin
        in_calm_left--;
        idle_left = 0;
      end else begin
        if ($urandom_range(0, 99) == 0) in_calm_left = $urandom_range(50, 200);
        idle_left = pick_idle();
      end
    end else begin
      // nothing left, or a held word waiting for the records to drain
      in_valid_i <= 1'b0;
    end
  end

  // output stall, independent of out_valid_o
  always @(negedge clk_i) begin
    if (!rst_ni || draining) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (out_calm_left > 0) begin
      out_stall_i <= 1'b0;
      out_calm_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      out_stall_i   <= 1'b0;
      out_calm_left = $urandom_range(50, 200);
    end else begin
      stall_left = pick_idle();
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // move buf_bytes into pending_words, end flag on the last byte
  task automatic send_buffer(input bit hold_first);
    in_word_t w;
    foreach (buf_bytes[i]) begin
      w.data = buf_bytes[i];
      w.eob  = (i == buf_bytes.size() - 1);
      w.hold = hold_first && (i == 0);
      pending_words.push_back(w);
    end
    word_total += buf_bytes.size();
    buf_bytes.delete();
  endtask

  // length byte, type byte, random body
  task automatic add_descriptor(input logic [7:0] len, input logic [7:0] kind);
    buf_bytes.push_back(len);
    buf_bytes.push_back(kind);
    for (int i = 2; i < len; i++) buf_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // one descriptor of a mostly realistic mix
  task automatic random_descriptor();
    int unsigned sel;
    int unsigned start;
    sel   = $urandom_range(0, 99);
    start = buf_bytes.size();
    if (sel < 40) begin
      // endpoint, now and then with trailing extra bytes
      add_descriptor(($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 10)) :
                     ucdp_pkg::MinEpLen, ucdp_pkg::KindEndpoint);
    end else if (sel < 65) begin
      add_descriptor(($urandom_range(0, 9) == 0) ? 8'($urandom_range(10, 12)) :
                     ucdp_pkg::MinIfaceLen, ucdp_pkg::KindInterface);
      // zero class keeps the latch open for a later interface
      if ($urandom_range(0, 2) == 0) buf_bytes[start + ucdp_pkg::IfaceFirstPos] = 8'd0;
    end else if (sel < 75) begin
      add_descriptor(8'($urandom_range(2, 6)), ucdp_pkg::KindEndpoint);
    end else if (sel < 82) begin
      add_descriptor(8'($urandom_range(2, 8)), ucdp_pkg::KindInterface);
    end else begin
      add_descriptor(8'($urandom_range(2, 12)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_buffer();
    int unsigned style;
    int unsigned cut;
    int unsigned keep;
    style = $urandom_range(0, 99);
    if (style < 10) begin
      // noise
      repeat ($urandom_range(1, 24)) buf_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_descriptor(ucdp_pkg::MinIfaceLen, KindConfig);
      if (style < 13) begin
        // more endpoints than the block records
        repeat ($urandom_range(EpLimit + 1, EpLimit + 4))
          add_descriptor(ucdp_pkg::MinEpLen, ucdp_pkg::KindEndpoint);
      end else begin
        repeat ($urandom_range(1, 8)) random_descriptor();
      end
      if (style >= 13 && style < 28) begin
        // bad length, then a short ignored tail
        buf_bytes.push_back(8'($urandom_range(0, 1)));
        buf_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) buf_bytes.push_back(8'($urandom_range(0, 255)));
      end
      cut = $urandom_range(0, 99);
      if (cut < 12) begin
        // lone trailing byte
        buf_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (cut < 32) begin
        // buffer ends at a random point
        keep = $urandom_range(1, buf_bytes.size());
        while (buf_bytes.size() > keep) void'(buf_bytes.pop_back());
      end
    end
    send_buffer($urandom_range(0, 29) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    clear_parse_state();

    // endpoint at the top of every field, completing on the final byte
    buf_bytes = '{8'd7, ucdp_pkg::KindEndpoint, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(1'b0);
    // interface with extreme class bytes, then a lone trailing byte; held for a drain
    buf_bytes = '{8'd9, ucdp_pkg::KindInterface, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h01, 8'h80,
                  8'h00, 8'h42};
    send_buffer(1'b1);
    // bad length with an ignored byte after it
    buf_bytes = '{8'd1, 8'hFF, 8'h33};
    send_buffer(1'b0);
    // length below 2 as the final byte: incomplete header only
    buf_bytes = '{8'd0};
    send_buffer(1'b0);
    // endpoint cut short by the buffer end
    buf_bytes = '{8'd7, ucdp_pkg::KindEndpoint, 8'h01, 8'h00, 8'h00};
    send_buffer(1'b0);

    while (word_total < WordTarget) random_buffer();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0) @(posedge clk_i);
    while (expected_recs.size() != 0) @(posedge clk_i);
    draining = 1'b1;
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && expected_recs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
